FILE: sv/prime_field_arith_unit_top_defines.svh
// Assertion macros for the modular arithmetic unit.
`ifndef PRIME_FIELD_ARITH_UNIT_TOP_DEFINES_SVH
`define PRIME_FIELD_ARITH_UNIT_TOP_DEFINES_SVH

// Checks that an antecedent implies a consequent in the next cycle.
`define PFA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle.
`define PFA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/pfa_pkg.sv
package pfa_pkg;

  localparam int unsigned WordBitsDefault = 64;
  localparam int unsigned ModBits = 63;
  localparam logic [62:0] ModReset = 63'h1FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    CMD_REDUCE = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_SUB    = 3'd2,
    CMD_MUL    = 3'd3,
    CMD_INV    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_ZERO    = 2'd1,
    STATUS_NOT_INV = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_OP,
    ST_MUL,
    ST_INV_DIV,
    ST_INV_MUL,
    ST_INV_UPD,
    ST_INV_END,
    ST_INV_NEXT,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED_A_STEP,
    OP_RED_B_STEP,
    OP_SIMPLE,
    OP_MUL_STEP,
    OP_INV_INIT,
    OP_DIV_STEP,
    OP_IMUL_INIT,
    OP_IMUL_STEP,
    OP_INV_UPD,
    OP_INV_FIN,
    OP_ZERO_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic step_last;
    logic nr_zero;
    logic a_zero;
    logic [2:0] cmd;
  } dp_status_t;

endpackage

FILE: sv/pfa_datapath.sv
module pfa_datapath import pfa_pkg::*; #(
  parameter int unsigned WORD_BITS = WordBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [ModBits-1:0]   mod_i,
  input  logic [2:0]           cmd_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] b_i,
  input  dp_cmd_t              dp_cmd_i,
  output dp_status_t           dp_status_o,
  output logic [ModBits-1:0]   result_o,
  output logic [1:0]           status_o
);

  localparam int unsigned CntBits = 7;
  localparam int unsigned W = ModBits + 1;

  logic [ModBits-1:0] m;
  assign m = (mod_i < ModBits'(2)) ? ModBits'(2) : mod_i;

  logic [2:0]           cmd_q, cmd_d;
  logic [WORD_BITS-1:0] a_q, a_d, b_q, b_d;
  logic [W-1:0]         rem_q, rem_d;
  logic [ModBits-1:0]   ar_q, ar_d, br_q, br_d;
  logic [ModBits-1:0]   r_q, r_d, nr_q, nr_d, t_q, t_d, nt_q, nt_d;
  logic [ModBits-1:0]   q_q, q_d, acc_q, acc_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [ModBits-1:0]   res_q, res_d;
  logic [1:0]           st_q, st_d;

  logic [W-1:0]       trial;
  logic [ModBits-1:0] accd, acca, divisor, sel_x, sel_y;
  logic               bit_in;

  function automatic logic [ModBits-1:0] addm(input logic [ModBits-1:0] x,
                                              input logic [ModBits-1:0] y,
                                              input logic [ModBits-1:0] md);
    logic [W-1:0] s;
    s = {1'b0, x} + {1'b0, y};
    addm = (s >= {1'b0, md}) ? ModBits'(s - {1'b0, md}) : ModBits'(s);
  endfunction

  always_comb begin
    bit_in = 1'b0;
    divisor = m;
    sel_x = ar_q;
    sel_y = br_q;
    if (dp_cmd_i.op == OP_RED_A_STEP) begin
      bit_in = a_q[cnt_q[$clog2(WORD_BITS)-1:0]];
    end else if (dp_cmd_i.op == OP_RED_B_STEP) begin
      bit_in = b_q[cnt_q[$clog2(WORD_BITS)-1:0]];
    end else begin
      bit_in = r_q[cnt_q[5:0]];
      divisor = nr_q;
    end
    if (dp_cmd_i.op == OP_IMUL_STEP) begin
      sel_x = nt_q;
      sel_y = q_q;
    end
    trial = {rem_q[W-2:0], bit_in};
    accd = addm(acc_q, acc_q, m);
    acca = addm(accd, sel_x, m);
  end

  logic [W-1:0] trial_sub;
  logic         trial_ge;
  assign trial_sub = trial - {1'b0, divisor};
  assign trial_ge  = trial >= {1'b0, divisor};

  always_comb begin
    cmd_d = cmd_q; a_d = a_q; b_d = b_q; rem_d = rem_q;
    ar_d = ar_q; br_d = br_q; r_d = r_q; nr_d = nr_q; t_d = t_q; nt_d = nt_q;
    q_d = q_q; acc_d = acc_q; cnt_d = cnt_q; res_d = res_q; st_d = st_q;
    case (dp_cmd_i.op)
      OP_LOAD: begin
        cmd_d = cmd_i; a_d = a_i; b_d = b_i; rem_d = '0;
        cnt_d = CntBits'(WORD_BITS - 1);
      end
      OP_RED_A_STEP, OP_RED_B_STEP: begin
        rem_d = trial_ge ? trial_sub : trial;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if (dp_cmd_i.op == OP_RED_A_STEP) begin
            ar_d = trial_ge ? ModBits'(trial_sub) : ModBits'(trial);
          end else begin
            br_d = trial_ge ? ModBits'(trial_sub) : ModBits'(trial);
          end
          rem_d = '0;
          cnt_d = CntBits'(WORD_BITS - 1);
        end
      end
      OP_SIMPLE: begin
        st_d = STATUS_OK;
        res_d = '0;
        acc_d = '0;
        cnt_d = CntBits'(ModBits - 1);
        case (cmd_q)
          CMD_REDUCE: res_d = ar_q;
          CMD_ADD:    res_d = addm(ar_q, br_q, m);
          CMD_SUB:    res_d = (ar_q >= br_q) ? ar_q - br_q : ar_q + (m - br_q);
          default:    res_d = '0;
        endcase
      end
      OP_MUL_STEP, OP_IMUL_STEP: begin
        acc_d = sel_y[cnt_q[5:0]] ? acca : accd;
        cnt_d = cnt_q - 1'b1;
        if (dp_cmd_i.op == OP_MUL_STEP && cnt_q == '0) begin
          res_d = sel_y[0] ? acca : accd;
        end
      end
      OP_INV_INIT: begin
        r_d = m; nr_d = ar_q; t_d = '0; nt_d = ModBits'(1);
        rem_d = '0; q_d = '0; cnt_d = CntBits'(ModBits - 1);
      end
      OP_DIV_STEP: begin
        rem_d = trial_ge ? trial_sub : trial;
        q_d = {q_q[ModBits-2:0], trial_ge};
        cnt_d = cnt_q - 1'b1;
      end
      OP_IMUL_INIT: begin
        acc_d = '0; cnt_d = CntBits'(ModBits - 1);
      end
      OP_INV_UPD: begin
        r_d = nr_q;
        nr_d = ModBits'(rem_q);
        t_d = nt_q;
        nt_d = (t_q >= acc_q) ? t_q - acc_q : t_q + (m - acc_q);
        rem_d = '0; q_d = '0; cnt_d = CntBits'(ModBits - 1);
      end
      OP_INV_FIN: begin
        if (r_q > ModBits'(1)) begin
          res_d = '0; st_d = STATUS_NOT_INV;
        end else begin
          res_d = t_q; st_d = STATUS_OK;
        end
      end
      OP_ZERO_OUT: begin
        res_d = '0; st_d = STATUS_ZERO;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; a_q <= a_d; b_q <= b_d; rem_q <= rem_d;
    ar_q <= ar_d; br_q <= br_d; r_q <= r_d; nr_q <= nr_d; t_q <= t_d;
    nt_q <= nt_d; q_q <= q_d; acc_q <= acc_d; res_q <= res_d; st_q <= st_d;
  end

  assign dp_status_o.step_last = (cnt_q == '0);
  assign dp_status_o.nr_zero   = (nr_q == '0);
  assign dp_status_o.a_zero    = (a_q == '0);
  assign dp_status_o.cmd       = cmd_q;
  assign result_o = res_q;
  assign status_o = st_q;

endmodule

FILE: sv/pfa_ctrl.sv
module pfa_ctrl import pfa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       cfg_ready_o,
  input  dp_status_t dp_status_i,
  output dp_cmd_t    dp_cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    dp_cmd_o.op = OP_NONE;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    cfg_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dp_cmd_o.op = OP_LOAD;
          state_d = ST_RED_A;
        end
      end
      ST_RED_A: begin
        dp_cmd_o.op = OP_RED_A_STEP;
        if (dp_status_i.step_last) state_d = ST_RED_B;
      end
      ST_RED_B: begin
        dp_cmd_o.op = OP_RED_B_STEP;
        if (dp_status_i.step_last) state_d = ST_OP;
      end
      ST_OP: begin
        if (dp_status_i.cmd == CMD_INV) begin
          if (dp_status_i.a_zero) begin
            dp_cmd_o.op = OP_ZERO_OUT;
            state_d = ST_OUT;
          end else begin
            dp_cmd_o.op = OP_INV_INIT;
            state_d = ST_INV_END;
          end
        end else begin
          dp_cmd_o.op = OP_SIMPLE;
          state_d = (dp_status_i.cmd == CMD_MUL) ? ST_MUL : ST_OUT;
        end
      end
      ST_MUL: begin
        dp_cmd_o.op = OP_MUL_STEP;
        if (dp_status_i.step_last) state_d = ST_OUT;
      end
      ST_INV_END: begin
        if (dp_status_i.nr_zero) begin
          dp_cmd_o.op = OP_INV_FIN;
          state_d = ST_OUT;
        end else begin
          state_d = ST_INV_DIV;
        end
      end
      ST_INV_DIV: begin
        dp_cmd_o.op = OP_DIV_STEP;
        if (dp_status_i.step_last) begin
          state_d = ST_INV_MUL;
        end
      end
      ST_INV_MUL: begin
        dp_cmd_o.op = OP_IMUL_INIT;
        state_d = ST_INV_UPD;
      end
      ST_INV_UPD: begin
        dp_cmd_o.op = OP_IMUL_STEP;
        if (dp_status_i.step_last) state_d = ST_INV_NEXT;
      end
      ST_INV_NEXT: begin
        dp_cmd_o.op = OP_INV_UPD;
        state_d = ST_INV_END;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: sv/prime_field_arith_unit_top.sv
// Reduce, add, subtract and unused commands reduce both operands bit-serially modulo the modulus, then
// compute the result in one operation state; multiply then adds a bit-serial double-and-add pass.
// Inverse runs Euclid steps, each with the divider, the multiplier and the ST_INV_MUL, ST_INV_NEXT
// and ST_INV_END control states.
// One request is in work at a time; the next is accepted in the cycle after the result is taken.
// Reset is asynchronous active low and loads the modulus with 2^61-1.
`include "prime_field_arith_unit_top_defines.svh"
module prime_field_arith_unit_top import pfa_pkg::*; #(
  parameter int unsigned WORD_BITS = WordBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // operand_a, operand_b
  input  logic [2*WORD_BITS-1:0] s_axis_tdata,
  // command
  input  logic [2:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // result
  output logic [63:0]          m_axis_tdata,
  // status
  output logic [1:0]           m_axis_tuser,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [ModBits-1:0]   cfg_data_i
);

  logic [ModBits-1:0] mod_q;
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic [ModBits-1:0] result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= ModReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mod_q <= cfg_data_i;
    end
  end

  pfa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cfg_ready_o, .dp_status_i(dp_status), .dp_cmd_o(dp_cmd)
  );

  pfa_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk_i, .rst_ni, .mod_i(mod_q), .cmd_i(s_axis_tuser),
    .a_i(s_axis_tdata[WORD_BITS-1:0]), .b_i(s_axis_tdata[2*WORD_BITS-1:WORD_BITS]),
    .dp_cmd_i(dp_cmd), .dp_status_o(dp_status),
    .result_o(result), .status_o(m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, result};

  `PFA_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
  `PFA_ASSERT_NOW(a_excl, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready, "busy overlap")
  `PFA_ASSERT_NOW(a_err, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser != STATUS_OK, result == '0, "error result")

endmodule
